>>> hdl/wsmm_pkg.sv
// ----------------------------------------------------------------------------
// wsmm_pkg
// Shared constants, types and register codes for the window sum min/max finder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsmm_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int MAX_WINDOW = 16;
  localparam int DATA_WIDTH = 16;

  localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int N_W     = $clog2(MAX_SIDE + 1);
  localparam int K_W     = $clog2(MAX_WINDOW + 1);
  localparam int HIST_AW = SLOT_W + COL_W;
  localparam int CSUM_W  = DATA_WIDTH + SLOT_W;
  localparam int SUM_W   = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int NSIZE_W    = 7;
  localparam int KSIZE_W    = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified element on its way to the back end
  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [COL_W-1:0]      col;
    logic [HIST_AW-1:0]    hist_addr;
    logic                  first_row;
    logic                  sub_hist;
    logic                  first_col;
    logic                  sub_col;
    logic                  win;
    logic                  last;
    logic [COL_W-1:0]      top_row;
    logic [COL_W-1:0]      left_col;
  } item_t;

  typedef struct packed {
    logic           restart;
    logic [K_W-1:0] k;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hdl/wsmm_front.sv
// ----------------------------------------------------------------------------
// wsmm_front
// Holds the size registers, tracks row/column/slot of each incoming element
// and tags it with everything the back end needs.
// ----------------------------------------------------------------------------
`default_nettype none

module wsmm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wsmm_pkg::DATA_WIDTH-1:0] element_value,
  input  logic                            q_full,
  output logic                            push,
  output wsmm_pkg::item_t                 push_item,
  output wsmm_pkg::ctrl_t                 ctrl
);
  import wsmm_pkg::*;

  logic [N_W-1:0]     n;
  logic [K_W-1:0]     k;
  logic [COL_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [SLOT_W-1:0]  slot;
  logic               cfg_wr;
  logic               cfg_hit;
  logic [NSIZE_W-1:0] n_raw;
  logic [KSIZE_W-1:0] k_raw;
  logic [K_W-1:0]     k_m1;
  logic               col_end;
  logic               row_end;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index == CFG_MATRIX_SIZE || cfg_index == CFG_WINDOW_SIZE);
  assign n_raw     = cfg_data[NSIZE_W-1:0];
  assign k_raw     = cfg_data[KSIZE_W-1:0];

  assign in_stall  = q_full;
  assign push      = in_valid && !in_stall;

  assign k_m1      = k - 1'b1;
  assign col_end   = (N_W'(col) == n - 1'b1);
  assign row_end   = (N_W'(row) == n - 1'b1);

  always_comb begin
    push_item           = '0;
    push_item.value     = element_value;
    push_item.col       = col;
    push_item.hist_addr = {slot, col};
    push_item.first_row = (row == '0);
    push_item.sub_hist  = (int'(row) >= int'(k));
    push_item.first_col = (col == '0);
    push_item.sub_col   = (int'(col) >= int'(k));
    push_item.win       = (int'(row) >= int'(k_m1)) && (int'(col) >= int'(k_m1));
    push_item.last      = col_end && row_end;
    push_item.top_row   = row - COL_W'(k_m1);
    push_item.left_col  = col - COL_W'(k_m1);
  end

  assign ctrl.restart = cfg_hit;
  assign ctrl.k       = k;

  // size registers, saturated to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= N_W'(MAX_SIDE);
      k <= K_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: begin
          if (n_raw == '0) n <= N_W'(1);
          else if (int'(n_raw) > MAX_SIDE) n <= N_W'(MAX_SIDE);
          else n <= N_W'(n_raw);
        end
        CFG_WINDOW_SIZE: begin
          if (k_raw == '0) k <= K_W'(1);
          else if (int'(k_raw) > MAX_WINDOW) k <= K_W'(MAX_WINDOW);
          else k <= K_W'(k_raw);
        end
        default: ;
      endcase
    end
  end

  // raster position; slot is the line store row (row mod k)
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
    end else if (push) begin
      if (col_end && row_end) begin
        row  <= '0;
        col  <= '0;
        slot <= '0;
      end else if (col_end) begin
        col  <= '0;
        row  <= row + 1'b1;
        slot <= (K_W'(slot) == k_m1) ? '0 : slot + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/wsmm_queue.sv
// ----------------------------------------------------------------------------
// wsmm_queue
// Short FIFO of classified elements between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module wsmm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsmm_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output wsmm_pkg::item_t head_item,
  input  logic            pop
);
  import wsmm_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wsmm_back.sv
// ----------------------------------------------------------------------------
// wsmm_back
// Line store and column sum memories, running window sum, min/max tracking
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsmm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  wsmm_pkg::ctrl_t                   ctrl,
  input  logic                              head_valid,
  input  wsmm_pkg::item_t                   head_item,
  output logic                              pop,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              found,
  output logic signed [wsmm_pkg::SUM_W-1:0] min_sum,
  output logic [wsmm_pkg::COL_W-1:0]        min_row,
  output logic [wsmm_pkg::COL_W-1:0]        min_col,
  output logic signed [wsmm_pkg::SUM_W-1:0] max_sum,
  output logic [wsmm_pkg::COL_W-1:0]        max_row,
  output logic [wsmm_pkg::COL_W-1:0]        max_col
);
  import wsmm_pkg::*;

  localparam int LINE_DEPTH = 2 ** SLOT_W;

  logic [DATA_WIDTH-1:0]    hist_mem [2 ** HIST_AW];
  logic [CSUM_W-1:0]        col_mem  [MAX_SIDE];

  // stage 2: memory data arrives, column sum update
  logic                     s2_valid;
  item_t                    s2_item;
  logic [DATA_WIDTH-1:0]    hist_rd;
  logic [CSUM_W-1:0]        col_rd;
  logic signed [CSUM_W-1:0] csum_new;

  // stage 3: window sum update and compare
  logic                     s3_valid;
  item_t                    s3_item;
  logic [CSUM_W-1:0]        s3_csum;
  logic [CSUM_W-1:0]        line [LINE_DEPTH];
  logic [CSUM_W-1:0]        tap;
  logic signed [SUM_W-1:0]  ws;
  logic signed [SUM_W-1:0]  ws_next;
  logic                     seen;
  logic                     seen_now;
  logic signed [SUM_W-1:0]  best_low;
  logic signed [SUM_W-1:0]  best_high;
  logic [COL_W-1:0]         low_row;
  logic [COL_W-1:0]         low_col;
  logic [COL_W-1:0]         high_row;
  logic [COL_W-1:0]         high_col;
  logic                     upd_low;
  logic                     upd_high;

  logic                     out_free;
  logic                     s3_adv;
  logic                     s3_ready;
  logic                     s2_adv;
  logic                     s2_ready;

  assign out_free = !out_valid || !out_stall;
  assign s3_adv   = s3_valid && (!s3_item.last || out_free);
  assign s3_ready = !s3_valid || s3_adv;
  assign s2_adv   = s2_valid && s3_ready;
  assign s2_ready = !s2_valid || s2_adv;
  assign pop      = head_valid && s2_ready;

  // read on entry to stage 2
  always_ff @(posedge clk) begin
    if (pop) begin
      hist_rd <= hist_mem[head_item.hist_addr];
      col_rd  <= col_mem[head_item.col];
      s2_item <= head_item;
    end
  end

  always_comb begin
    csum_new = {{SLOT_W{s2_item.value[DATA_WIDTH-1]}}, s2_item.value};
    if (!s2_item.first_row) csum_new = csum_new + $signed(col_rd);
    if (s2_item.sub_hist)
      csum_new = csum_new - $signed({{SLOT_W{hist_rd[DATA_WIDTH-1]}}, hist_rd});
  end

  // write back as the element leaves stage 2
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      hist_mem[s2_item.hist_addr] <= s2_item.value;
      col_mem[s2_item.col]        <= csum_new;
      s3_item                     <= s2_item;
      s3_csum                     <= csum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (pop)         s2_valid <= 1'b1;
      else if (s2_adv) s2_valid <= 1'b0;
      if (s2_adv)      s3_valid <= 1'b1;
      else if (s3_adv) s3_valid <= 1'b0;
    end
  end

  // column sum from k columns back in the same row
  assign tap = line[SLOT_W'(ctrl.k - 1'b1)];

  always_comb begin
    ws_next = s3_item.first_col ? '0 : ws;
    ws_next = ws_next + SUM_W'($signed(s3_csum));
    if (s3_item.sub_col) ws_next = ws_next - SUM_W'($signed(tap));
  end

  assign upd_low  = s3_item.win && (!seen || ws_next < best_low);
  assign upd_high = s3_item.win && (!seen || ws_next > best_high);
  assign seen_now = seen || s3_item.win;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      line[0] <= s3_csum;
      for (int i = 1; i < LINE_DEPTH; i++) line[i] <= line[i-1];
      ws <= ws_next;
      if (upd_low) begin
        best_low <= ws_next;
        low_row  <= s3_item.top_row;
        low_col  <= s3_item.left_col;
      end
      if (upd_high) begin
        best_high <= ws_next;
        high_row  <= s3_item.top_row;
        high_col  <= s3_item.left_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      seen <= 1'b0;
    end else if (s3_adv) begin
      seen <= s3_item.last ? 1'b0 : seen_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_adv && s3_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s3_item.last) begin
      found <= seen_now;
      if (seen_now) begin
        min_sum <= upd_low ? ws_next : best_low;
        min_row <= upd_low ? s3_item.top_row : low_row;
        min_col <= upd_low ? s3_item.left_col : low_col;
        max_sum <= upd_high ? ws_next : best_high;
        max_row <= upd_high ? s3_item.top_row : high_row;
        max_col <= upd_high ? s3_item.left_col : high_col;
      end else begin
        min_sum <= '0;
        min_row <= '0;
        min_col <= '0;
        max_sum <= '0;
        max_row <= '0;
        max_col <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/window_sum_min_max_finder.sv
// ----------------------------------------------------------------------------
// window_sum_min_max_finder
// Streaming k x k box sum over an n x n matrix, reporting min and max windows.
// ----------------------------------------------------------------------------
// Send the n*n elements of a matrix in row-major order, one per cycle at full
// rate; the block takes a new element every cycle unless the result register
// is full and the downstream side stalls. One result comes out per matrix,
// after its last element passes stages 2 and 3: the smallest and largest
// k x k window sums with their top-left corners (first in raster order on
// ties), or found = 0 when k exceeds n. The running window-sum add and compare
// in the last stage sets the one-element-per-cycle rate. Write matrix_size or
// window_size only between matrices; either write restarts the matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module window_sum_min_max_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsmm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [wsmm_pkg::DATA_WIDTH-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic signed [wsmm_pkg::SUM_W-1:0] min_sum,
  output logic [wsmm_pkg::COL_W-1:0]        min_row,
  output logic [wsmm_pkg::COL_W-1:0]        min_col,
  output logic signed [wsmm_pkg::SUM_W-1:0] max_sum,
  output logic [wsmm_pkg::COL_W-1:0]        max_row,
  output logic [wsmm_pkg::COL_W-1:0]        max_col
);
  import wsmm_pkg::*;

  logic  push;
  item_t push_item;
  ctrl_t ctrl;
  logic  q_full;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  wsmm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item),
    .ctrl          (ctrl)
  );

  wsmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  wsmm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .found      (found),
    .min_sum    (min_sum),
    .min_row    (min_row),
    .min_col    (min_col),
    .max_sum    (max_sum),
    .max_row    (max_row),
    .max_col    (max_col)
  );

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> min_sum <= max_sum)
    else $error("minimum window sum above maximum");

  a_not_found_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> min_sum == '0 && max_sum == '0 && min_row == '0 &&
                            min_col == '0 && max_row == '0 && max_col == '0)
    else $error("not-found result carries nonzero fields");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("back end took an element from an empty queue");

endmodule

`default_nettype wire
